@@ design/stream_search_replace_defines.svh @@
`ifndef STREAM_SEARCH_REPLACE_DEFINES_SVH
`define STREAM_SEARCH_REPLACE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ssr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = BYTE_W * MAX_PATTERN;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int QUEUE_DEPTH = 2 * MAX_PATTERN;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH  = 2'd3;

  // One result word as it sits in the output queue.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              fin;
    logic              last;
  } result_t;

  // Control shared by all window cells.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             load;
    logic             shift;
    logic             write;
  } win_ctl_t;

  // Control shared by all queue cells.
  typedef struct packed {
    logic [FILL_W-1:0] base;
    logic [CNT_W-1:0]  n;
    logic              push;
    logic              pop;
  } queue_ctl_t;

endpackage
`default_nettype wire

@@ design/stream_search_replace.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An item's result words enter the queue when it is taken and leave after the words ahead.
// Throughput: one item and one result word per cycle when unstalled; the queue holds 16 words.
// An item that causes up to eight results is taken while at most eight words are queued,
// so the input stalls only when the output side falls behind.
// Reset (rst, synchronous, active high) clears the registers, emptying window and queue.
module stream_search_replace (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::PAT_W-1:0]     cfg_data,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  logic [ssr_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_valid,
  input  logic                          in_end,
  output logic                          down_valid,
  input  logic                          down_stall,
  output logic [ssr_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_valid,
  output logic                          out_end,
  output logic                          run_last
);
  import ssr_pkg::*;

  function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    return (v > LEN_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : CNT_W'(v);
  endfunction

  logic [PAT_W-1:0]  search_pattern;
  logic [LEN_W-1:0]  search_length;
  logic [PAT_W-1:0]  replace_pattern;
  logic [LEN_W-1:0]  replace_length;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic [CNT_W-1:0]  slen;
  logic [CNT_W-1:0]  rlen;
  logic [CNT_W-1:0]  count_new;
  logic [CNT_W-1:0]  n_data;
  logic [CNT_W-1:0]  n;
  logic              take;
  logic              load;
  logic              full;
  logic              hit;
  logic              miss;
  logic              pass;
  logic              marker;
  logic              pop;

  win_ctl_t          win_ctl;
  queue_ctl_t        q_ctl;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_new;
  logic [MAX_PATTERN-1:0]             match;
  result_t [MAX_PATTERN-1:0]          burst;
  result_t [QUEUE_DEPTH-1:0]          entry;

  assign slen = clamp_len(search_length);
  assign rlen = clamp_len(replace_length);

  assign take      = up_valid && !up_stall;
  assign load      = take && in_valid;
  assign count_new = count + CNT_W'(load);
  assign full      = load && (slen != '0) && (count_new == slen);
  assign hit       = full && (&match);
  assign miss      = full && !hit;
  assign pass      = load && (slen == '0);

  always_comb begin
    priority if (hit) begin
      n_data = rlen;
    end else if (pass) begin
      n_data = CNT_W'(1);
    end else if (miss) begin
      n_data = in_end ? slen : CNT_W'(1);
    end else begin
      n_data = in_end ? count_new : '0;
    end
  end

  assign marker = in_end && (n_data == '0);
  assign n      = marker ? CNT_W'(1) : n_data;

  always_comb begin
    priority if (!take) begin
      count_next = count;
    end else if (in_end || hit || pass) begin
      count_next = '0;
    end else if (miss) begin
      count_next = slen - CNT_W'(1);
    end else begin
      count_next = count_new;
    end
  end

  // Window: a row of cells, each compared against its own search byte.
  assign win_ctl.count = count;
  assign win_ctl.load  = load;
  assign win_ctl.shift = miss;
  assign win_ctl.write = take;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_win
    logic [BYTE_W-1:0] neighbour;
    if (k + 1 < MAX_PATTERN) begin : g_mid
      assign neighbour = win_new[k+1];
    end else begin : g_end
      assign neighbour = '0;
    end
    ssr_win_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(k)),
      .ctl        (win_ctl),
      .in_byte    (in_byte),
      .next_value (neighbour),
      .pat_byte   (search_pattern[BYTE_W*k +: BYTE_W]),
      .slen       (slen),
      .value_new  (win_new[k]),
      .match      (match[k])
    );
  end

  // Results of this item: replacement bytes on a hit, otherwise a prefix of the window or an empty end word.
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      burst[j].data  = hit ? replace_pattern[BYTE_W*j +: BYTE_W] : win_new[j];
      burst[j].valid = 1'b1;
      burst[j].last  = (CNT_W'(j) == (n - CNT_W'(1)));
      burst[j].fin   = in_end && burst[j].last;
    end
    if (marker) begin
      burst[0] = '{data: '0, valid: 1'b0, fin: 1'b1, last: 1'b1};
    end
  end

  // Output queue: a row of cells shifting toward the port.
  assign pop        = down_valid && !down_stall;
  assign q_ctl.base = fill - FILL_W'(pop);
  assign q_ctl.n    = n;
  assign q_ctl.push = take;
  assign q_ctl.pop  = pop;
  assign fill_next  = q_ctl.base + (take ? FILL_W'(n) : '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
    result_t behind;
    if (i + 1 < QUEUE_DEPTH) begin : g_mid
      assign behind = entry[i+1];
    end else begin : g_end
      assign behind = '0;
    end
    ssr_queue_cell u_cell (
      .clk        (clk),
      .idx        (QIDX_W'(i)),
      .ctl        (q_ctl),
      .burst      (burst),
      .next_entry (behind),
      .entry      (entry[i])
    );
  end

  assign up_stall   = fill > FILL_W'(QUEUE_DEPTH - MAX_PATTERN);
  assign down_valid = (fill != '0);
  assign out_byte   = entry[0].data;
  assign out_valid  = entry[0].valid;
  assign out_end    = entry[0].fin;
  assign run_last   = entry[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern  <= '0;
      search_length   <= '0;
      replace_pattern <= '0;
      replace_length  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEARCH_PATTERN:  search_pattern  <= cfg_data;
        REG_SEARCH_LENGTH:   search_length   <= cfg_data[LEN_W-1:0];
        REG_REPLACE_PATTERN: replace_pattern <= cfg_data;
        REG_REPLACE_LENGTH:  replace_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fill  <= '0;
    end else begin
      fill <= fill_next;
      // Drop pending bytes when the search length register is written.
      if (cfg_write && (cfg_index == REG_SEARCH_LENGTH)) begin
        count <= '0;
      end else begin
        count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ssr_win_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssr_win_cell (
  input  logic                       clk,
  input  logic [ssr_pkg::IDX_W-1:0]  idx,
  input  ssr_pkg::win_ctl_t          ctl,
  input  logic [ssr_pkg::BYTE_W-1:0] in_byte,
  input  logic [ssr_pkg::BYTE_W-1:0] next_value,
  input  logic [ssr_pkg::BYTE_W-1:0] pat_byte,
  input  logic [ssr_pkg::CNT_W-1:0]  slen,
  output logic [ssr_pkg::BYTE_W-1:0] value_new,
  output logic                       match
);
  import ssr_pkg::*;

  logic [BYTE_W-1:0] value;

  // The arriving byte lands in the first free cell.
  assign value_new = (ctl.load && (ctl.count == CNT_W'(idx))) ? in_byte : value;

  // Cells past the search length always agree.
  assign match = (value_new == pat_byte) || (CNT_W'(idx) >= slen);

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      value <= ctl.shift ? next_value : value_new;
    end
  end

endmodule
`default_nettype wire

@@ design/ssr_queue_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssr_queue_cell (
  input  logic                                  clk,
  input  logic [ssr_pkg::QIDX_W-1:0]            idx,
  input  ssr_pkg::queue_ctl_t                   ctl,
  input  ssr_pkg::result_t [ssr_pkg::MAX_PATTERN-1:0] burst,
  input  ssr_pkg::result_t                      next_entry,
  output ssr_pkg::result_t                      entry
);
  import ssr_pkg::*;

  logic [FILL_W-1:0] offset;
  logic              insert;

  // Position of this cell relative to the first free slot after the pop.
  assign offset = FILL_W'(idx) - ctl.base;
  assign insert = ctl.push && (offset < FILL_W'(ctl.n));

  always_ff @(posedge clk) begin
    if (insert) begin
      entry <= burst[offset[IDX_W-1:0]];
    end else if (ctl.pop) begin
      entry <= next_entry;
    end
  end

endmodule
`default_nettype wire

@@ design/ssr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "stream_search_replace_defines.svh"
module ssr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          down_valid,
  input  logic                          down_stall,
  input  logic [ssr_pkg::BYTE_W-1:0]    out_byte,
  input  logic                          out_valid,
  input  logic                          out_end,
  input  logic                          run_last
);

  // An empty word only ever closes a string.
  `SSR_ASSERT_NOW(a_marker_shape, down_valid && !out_valid,
                  (out_byte == '0) && out_end && run_last, "empty word malformed")

  // The end of a string is always the last word of its item.
  `SSR_ASSERT_NOW(a_end_is_last, down_valid && out_end, run_last, "end word not last of item")

  // Hold a stalled word.
  `SSR_ASSERT_NEXT(a_hold_stalled, down_valid && down_stall,
                   down_valid && $stable(out_byte) && $stable(out_valid) &&
                   $stable(out_end) && $stable(run_last), "stalled word changed")

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (.*);
`default_nettype wire
